/* design/vertex_transform_4x4_macros.svh */
// Assertion macros shared by the vertex transform design files.
// Depends on nothing; expects i_clk and i_rst_n in the including module.
`ifndef VERTEX_TRANSFORM_4X4_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define VT44_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// An antecedent that must be followed by a consequent in the same cycle.
`define VT44_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/vt44_pkg.sv */
// Shared types and constants for the 4x4 vertex transform.
// Depends on nothing; used by every module of the block.
`default_nettype none

package vt44_pkg;

    localparam int FIELD_W   = 32;
    localparam int CFG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int VEC_N     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_COLS01 = 4'd0,
        REG_ROW0_COLS23 = 4'd1,
        REG_ROW1_COLS01 = 4'd2,
        REG_ROW1_COLS23 = 4'd3,
        REG_ROW2_COLS01 = 4'd4,
        REG_ROW2_COLS23 = 4'd5,
        REG_ROW3_COLS01 = 4'd6,
        REG_ROW3_COLS23 = 4'd7
    } t_reg_idx;

    // Forward control that travels with each pipeline stage.
    typedef struct packed {
        logic valid;
        logic dir;
    } t_fwd;

endpackage

`default_nettype wire

/* design/vt44_matrix.sv */
// Matrix configuration registers with identity reset, unpacked into elements.
// Depends on vt44_pkg.
`default_nettype none

module vt44_matrix #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [vt44_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [vt44_pkg::CFG_W-1:0]             i_cfg_data,
    output logic [15:0][ELEM_WIDTH-1:0]                 o_elem
);

    localparam logic [vt44_pkg::CFG_W-1:0] ONE_LO = vt44_pkg::CFG_W'(1) << FRAC_BITS;
    localparam logic [vt44_pkg::CFG_W-1:0] ONE_HI = ONE_LO << 32;

    logic [vt44_pkg::NUM_REGS-1:0][vt44_pkg::CFG_W-1:0] r_regs;
    logic                                                 w_wr;

    function automatic logic [vt44_pkg::NUM_REGS-1:0][vt44_pkg::CFG_W-1:0] identity_regs();
        logic [vt44_pkg::NUM_REGS-1:0][vt44_pkg::CFG_W-1:0] v;
        v = '0;
        v[vt44_pkg::REG_ROW0_COLS01] = ONE_LO;
        v[vt44_pkg::REG_ROW1_COLS01] = ONE_HI;
        v[vt44_pkg::REG_ROW2_COLS23] = ONE_LO;
        v[vt44_pkg::REG_ROW3_COLS23] = ONE_HI;
        return v;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign w_wr = i_cfg_valid && (i_cfg_index < vt44_pkg::CFG_IDX_W'(vt44_pkg::NUM_REGS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= identity_regs();
        end else if (w_wr) begin
            r_regs[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    for (genvar k = 0; k < 16; k++) begin : g_elem
        assign o_elem[k] = r_regs[(k / 4) * 2 + (k % 4) / 2][((k % 4) % 2) * 32 +: ELEM_WIDTH];
    end

endmodule

`default_nettype wire

/* design/vt44_mul.sv */
// Input capture stage and the sixteen element products, one register each.
// Depends on vt44_pkg.
`default_nettype none

module vt44_mul #(
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_valid,
    output logic                                            o_ready,
    input  wire logic [vt44_pkg::VEC_N*vt44_pkg::FIELD_W-1:0] i_vec,
    input  wire logic                                       i_dir,
    input  wire logic [15:0][ELEM_WIDTH-1:0]                i_elem,
    output vt44_pkg::t_fwd                                  o_fwd,
    input  wire logic                                       i_ready,
    output logic [15:0][2*ELEM_WIDTH-1:0]                   o_prod
);

    localparam int PW = 2 * ELEM_WIDTH;

    vt44_pkg::t_fwd                       r_fwd1, r_fwd2;
    logic [3:0][ELEM_WIDTH-1:0]           r_vec, n_vec;
    logic [15:0][PW-1:0]                  r_prod, n_prod;
    logic                                 w_rdy1, w_rdy2;

    assign w_rdy2  = !r_fwd2.valid || i_ready;
    assign w_rdy1  = !r_fwd1.valid || w_rdy2;
    assign o_ready = w_rdy1;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_vec[c] = i_vec[c*vt44_pkg::FIELD_W +: ELEM_WIDTH];
        end
        if (i_dir) begin
            n_vec[3] = '0;
        end
    end

    for (genvar k = 0; k < 16; k++) begin : g_prod
        assign n_prod[k] = $signed(i_elem[k]) * $signed(r_vec[k % 4]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd1 <= '0;
            r_fwd2 <= '0;
        end else begin
            if (w_rdy1) begin
                r_fwd1.valid <= i_valid;
                r_fwd1.dir   <= i_dir;
            end
            if (w_rdy2) begin
                r_fwd2 <= r_fwd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_vec <= n_vec;
        end
        if (w_rdy2 && r_fwd1.valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_fwd  = r_fwd2;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* design/vt44_sum.sv */
// Two-level registered adder tree forming each row's exact dot product.
// Depends on vt44_pkg.
`default_nettype none

module vt44_sum #(
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire vt44_pkg::t_fwd                     i_fwd,
    output logic                                    o_ready,
    input  wire logic [15:0][2*ELEM_WIDTH-1:0]      i_prod,
    output vt44_pkg::t_fwd                          o_fwd,
    input  wire logic                               i_ready,
    output logic [3:0][2*ELEM_WIDTH+1:0]            o_sum
);

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int AW = PW + 1;
    localparam int SW = PW + 2;

    vt44_pkg::t_fwd          r_fwd3, r_fwd4;
    logic [7:0][AW-1:0]      r_pair, n_pair;
    logic [3:0][SW-1:0]      r_sum, n_sum;
    logic                    w_rdy3, w_rdy4;

    assign w_rdy4  = !r_fwd4.valid || i_ready;
    assign w_rdy3  = !r_fwd3.valid || w_rdy4;
    assign o_ready = w_rdy3;

    for (genvar j = 0; j < 8; j++) begin : g_pair
        assign n_pair[j] = AW'($signed(i_prod[2*j])) + AW'($signed(i_prod[2*j+1]));
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        assign n_sum[r] = SW'($signed(r_pair[2*r])) + SW'($signed(r_pair[2*r+1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd3 <= '0;
            r_fwd4 <= '0;
        end else begin
            if (w_rdy3) begin
                r_fwd3 <= i_fwd;
            end
            if (w_rdy4) begin
                r_fwd4 <= r_fwd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_fwd.valid) begin
            r_pair <= n_pair;
        end
        if (w_rdy4 && r_fwd3.valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_fwd = r_fwd4;
    assign o_sum = r_sum;

endmodule

`default_nettype wire

/* design/vt44_sat.sv */
// Rounding toward minus infinity, saturation and the output register.
// Depends on vt44_pkg.
`default_nettype none

module vt44_sat #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire vt44_pkg::t_fwd                             i_fwd,
    output logic                                            o_ready,
    input  wire logic [3:0][2*ELEM_WIDTH+1:0]               i_sum,
    output vt44_pkg::t_fwd                                  o_fwd,
    input  wire logic                                       i_ready,
    output logic [vt44_pkg::VEC_N*vt44_pkg::FIELD_W-1:0]   o_res,
    output logic                                            o_sat
);

    localparam int SW = 2 * ELEM_WIDTH + 2;
    localparam int FW = vt44_pkg::FIELD_W;
    localparam logic [ELEM_WIDTH-1:0] EHI = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH-1:0] ELO = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    vt44_pkg::t_fwd                       r_fwd5;
    logic [3:0][FW-1:0]                   r_res, n_res;
    logic                                 r_sat, n_sat;
    logic [3:0]                           w_clip;
    logic [3:0][ELEM_WIDTH-1:0]           w_val;
    logic                                 w_rdy5;

    assign w_rdy5  = !r_fwd5.valid || i_ready;
    assign o_ready = w_rdy5;

    for (genvar r = 0; r < 4; r++) begin : g_row
        logic signed [SW-1:0]   w_q;
        logic [SW-ELEM_WIDTH:0] w_top;
        assign w_q       = $signed(i_sum[r]) >>> FRAC_BITS;
        assign w_top     = w_q[SW-1:ELEM_WIDTH-1];
        assign w_clip[r] = !((&w_top) || !(|w_top));
        assign w_val[r]  = w_clip[r] ? (w_q[SW-1] ? ELO : EHI) : w_q[ELEM_WIDTH-1:0];
        if (r < 3) begin : g_plain
            assign n_res[r] = FW'($signed(w_val[r]));
        end else begin : g_w
            assign n_res[r] = i_fwd.dir ? '0 : FW'($signed(w_val[r]));
        end
    end

    assign n_sat = (|w_clip[2:0]) || (w_clip[3] && !i_fwd.dir);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd5 <= '0;
        end else if (w_rdy5) begin
            r_fwd5 <= i_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && i_fwd.valid) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign o_fwd = r_fwd5;
    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

/* design/vertex_transform_4x4.sv */
// Top level of the 4x4 vertex transform: matrix registers and five-stage pipeline.
// Depends on vt44_pkg, vt44_matrix, vt44_mul, vt44_sum, vt44_sat and the macro header.
//
// Usage: a vector (x, y, z, w) enters on the s_axis channel; tuser bit 0 selects
// direction mode, in which w is taken as zero and res_w is returned as zero.
// Each result on the m_axis channel is the matrix times the vector, rounded down
// to FRAC_BITS fraction bits and saturated; tuser bit 0 reports any clipping.
// The matrix is written through the cfg channel, one 64-bit register per
// transaction (index 0 to 7, two elements each); other indexes are ignored.
// Write the matrix only while no transaction is in flight.
// The input register loads at the accepting edge, then the product, pair-sum,
// row-sum and saturation registers follow in that order. Throughput is one vector
// per cycle while the receiver takes every result. When the receiver stalls, each
// stage holds and fills in turn, so up to five vectors are buffered before
// s_axis_tready falls; nothing is lost.
// Reset clears all pipeline valid bits and loads the identity matrix.
`default_nettype none

`include "vertex_transform_4x4_macros.svh"

module vertex_transform_4x4 #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    // tdata: vec_x [31:0], vec_y [63:32], vec_z [95:64], vec_w [127:96]
    input  wire logic [vt44_pkg::VEC_N*vt44_pkg::FIELD_W-1:0] i_s_axis_tdata,
    // tuser: is_direction [0]
    input  wire logic [0:0]                                 i_s_axis_tuser,
    input  wire logic                                       i_s_axis_tvalid,
    output logic                                            o_s_axis_tready,
    // tdata: res_x [31:0], res_y [63:32], res_z [95:64], res_w [127:96]
    output logic [vt44_pkg::VEC_N*vt44_pkg::FIELD_W-1:0]   o_m_axis_tdata,
    // tuser: saturated [0]
    output logic [0:0]                                      o_m_axis_tuser,
    output logic                                            o_m_axis_tvalid,
    input  wire logic                                       i_m_axis_tready,
    input  wire logic                                       i_cfg_valid,
    output logic                                            o_cfg_ready,
    input  wire logic [vt44_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  wire logic [vt44_pkg::CFG_W-1:0]                 i_cfg_data
);

    localparam int FW = vt44_pkg::FIELD_W;
    localparam logic signed [ELEM_WIDTH-1:0] EHI = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [ELEM_WIDTH-1:0] ELO = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
    localparam logic [FW-1:0] SAT_HI = FW'(EHI);
    localparam logic [FW-1:0] SAT_LO = FW'(ELO);

    logic [15:0][ELEM_WIDTH-1:0]        w_elem;
    logic [15:0][2*ELEM_WIDTH-1:0]      w_prod;
    logic [3:0][2*ELEM_WIDTH+1:0]       w_sum;
    vt44_pkg::t_fwd                     w_fwd_mul, w_fwd_sum, w_fwd_out;
    logic                               w_rdy_sum, w_rdy_sat;
    logic                               w_sat;

    vt44_matrix #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_matrix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_elem      (w_elem)
    );

    vt44_mul #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_vec   (i_s_axis_tdata),
        .i_dir   (i_s_axis_tuser[0]),
        .i_elem  (w_elem),
        .o_fwd   (w_fwd_mul),
        .i_ready (w_rdy_sum),
        .o_prod  (w_prod)
    );

    vt44_sum #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fwd   (w_fwd_mul),
        .o_ready (w_rdy_sum),
        .i_prod  (w_prod),
        .o_fwd   (w_fwd_sum),
        .i_ready (w_rdy_sat),
        .o_sum   (w_sum)
    );

    vt44_sat #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fwd   (w_fwd_sum),
        .o_ready (w_rdy_sat),
        .i_sum   (w_sum),
        .o_fwd   (w_fwd_out),
        .i_ready (i_m_axis_tready),
        .o_res   (o_m_axis_tdata),
        .o_sat   (w_sat)
    );

    assign o_m_axis_tvalid   = w_fwd_out.valid;
    assign o_m_axis_tuser[0] = w_sat;

    // An empty output register means every stage can advance.
    `VT44_ASSERT_IMP(a_ready_when_drained, !o_m_axis_tvalid, o_s_axis_tready, "input stalled with empty output")

    // In direction mode the w component is always returned as zero.
    `VT44_ASSERT_IMP(a_dir_w_zero, w_fwd_out.valid && w_fwd_out.dir, o_m_axis_tdata[127:96] == '0, "w not zero in direction mode")

    // A clipped result carries at least one component at a range limit.
    `VT44_ASSERT_IMP(a_sat_at_limit, o_m_axis_tvalid && o_m_axis_tuser[0], (o_m_axis_tdata[31:0] == SAT_HI) || (o_m_axis_tdata[31:0] == SAT_LO) || (o_m_axis_tdata[63:32] == SAT_HI) || (o_m_axis_tdata[63:32] == SAT_LO) || (o_m_axis_tdata[95:64] == SAT_HI) || (o_m_axis_tdata[95:64] == SAT_LO) || (o_m_axis_tdata[127:96] == SAT_HI) || (o_m_axis_tdata[127:96] == SAT_LO), "saturation flag without a clipped component")

    // The configuration channel never back-pressures.
    `VT44_ASSERT_ALWAYS(a_cfg_ready, o_cfg_ready, "configuration channel not ready")

endmodule

`default_nettype wire

/* test/vt44_checker.sv */
`timescale 1ns / 100ps
// Result checker for vertex_transform_4x4: mirrors the matrix from the cfg channel,
// predicts each transformed vector and compares it with the m_axis output.
// Depends on vt44_pkg; instantiated by tb beside the block.
module vt44_checker #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic [vt44_pkg::VEC_N*vt44_pkg::FIELD_W-1:0] i_s_tdata,
    input  wire logic [0:0]                                   i_s_tuser,
    input  wire logic                                         i_s_tvalid,
    input  wire logic                                         i_s_tready,
    input  wire logic [vt44_pkg::VEC_N*vt44_pkg::FIELD_W-1:0] i_m_tdata,
    input  wire logic [0:0]                                   i_m_tuser,
    input  wire logic                                         i_m_tvalid,
    input  wire logic                                         i_m_tready,
    input  wire logic                                         i_cfg_valid,
    input  wire logic                                         i_cfg_ready,
    input  wire logic [vt44_pkg::CFG_IDX_W-1:0]               i_cfg_index,
    input  wire logic [vt44_pkg::CFG_W-1:0]                   i_cfg_data,
    output int                                                o_errors,
    output int                                                o_pending,
    output int                                                o_checked,
    output int                                                o_clipped
);
    import vt44_pkg::*;

    typedef struct packed {
        logic [VEC_N*FIELD_W-1:0] data;
        logic                     sat;
    } t_vertex_out;

    logic [CFG_W-1:0] matrix [NUM_REGS];
    t_vertex_out      awaited_vertices [$];
    t_vertex_out      want;
    string            field_name [VEC_N] = '{"res_x", "res_y", "res_z", "res_w"};

    function automatic logic signed [63:0] widen(input logic [FIELD_W-1:0] raw);
        logic signed [FIELD_W-1:0] t;
        t = raw << (FIELD_W - ELEM_WIDTH);
        return t >>> (FIELD_W - ELEM_WIDTH);
    endfunction

    function automatic t_vertex_out transform_vertex(input logic [VEC_N*FIELD_W-1:0] vec,
                                                     input logic dir);
        logic signed [63:0] v [VEC_N];
        logic signed [71:0] acc;
        logic signed [71:0] q;
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        logic [CFG_W-1:0]   r;
        t_vertex_out        res;
        hi  = (72'sd1 <<< (ELEM_WIDTH - 1)) - 72'sd1;
        lo  = -hi - 72'sd1;
        res = '0;
        for (int c = 0; c < VEC_N; c++) begin
            v[c] = widen(vec[c*FIELD_W +: FIELD_W]);
        end
        if (dir) begin
            v[VEC_N-1] = '0;
        end
        for (int row = 0; row < VEC_N; row++) begin
            if (!(dir && row == VEC_N - 1)) begin
                acc = '0;
                for (int c = 0; c < VEC_N; c++) begin
                    r = matrix[row*2 + c/2];
                    acc += widen(r[(c%2)*FIELD_W +: FIELD_W]) * v[c];
                end
                q = acc >>> FRAC_BITS;
                if (q > hi) begin
                    q = hi;
                    res.sat = 1'b1;
                end else if (q < lo) begin
                    q = lo;
                    res.sat = 1'b1;
                end
                res.data[row*FIELD_W +: FIELD_W] = q[FIELD_W-1:0];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                matrix[i] = '0;
            end
            matrix[REG_ROW0_COLS01] = {32'd0, 32'd1 << FRAC_BITS};
            matrix[REG_ROW1_COLS01] = {32'd1 << FRAC_BITS, 32'd0};
            matrix[REG_ROW2_COLS23] = {32'd0, 32'd1 << FRAC_BITS};
            matrix[REG_ROW3_COLS23] = {32'd1 << FRAC_BITS, 32'd0};
            awaited_vertices.delete();
            o_errors  = 0;
            o_checked = 0;
            o_clipped = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_REGS) begin
                matrix[i_cfg_index] = i_cfg_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_vertices.size() == 0) begin
                    o_errors++;
                    $error("result transaction arrived with no vector outstanding");
                end else begin
                    want = awaited_vertices.pop_front();
                    o_checked++;
                    if (want.sat) begin
                        o_clipped++;
                    end
                    for (int f = 0; f < VEC_N; f++) begin
                        if (i_m_tdata[f*FIELD_W +: FIELD_W] !== want.data[f*FIELD_W +: FIELD_W])
                        begin
                            o_errors++;
                            $error("%s mismatch: expected %0d, got %0d", field_name[f],
                                   $signed(want.data[f*FIELD_W +: FIELD_W]),
                                   $signed(i_m_tdata[f*FIELD_W +: FIELD_W]));
                        end
                    end
                    if (i_m_tuser[0] !== want.sat) begin
                        o_errors++;
                        $error("saturated mismatch: expected %0d, got %0d", want.sat,
                               i_m_tuser[0]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_vertices.push_back(transform_vertex(i_s_tdata, i_s_tuser[0]));
            end
        end
        o_pending <= awaited_vertices.size();
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench top for vertex_transform_4x4: clock, reset, vector and matrix stimulus,
// output back-pressure, watchdog and verdict. Depends on vt44_pkg and vt44_checker.
module tb;
    import vt44_pkg::*;

    localparam int ELEM_WIDTH     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int PIPE_DEPTH     = 5;
    localparam int STALL_LIMIT    = 2000;
    localparam int SQUEEZE_CYCLES = 60;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_VECTORS  = 215;

    localparam logic [FIELD_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] Q_ONE  = 32'd1 << FRAC_BITS;
    localparam logic [FIELD_W-1:0] Q_HALF = 32'd1 << (FRAC_BITS - 1);
    localparam logic [FIELD_W-1:0] Q_NEG  = '1;

    typedef enum int {MIX_FULL, MIX_SMALL, MIX_EDGE, MIX_ANY} t_mix;
    typedef enum int {SINK_OPEN, SINK_HALF, SINK_EASY, SINK_BUSY} t_sink;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic [VEC_N*FIELD_W-1:0] s_tdata   = '0;
    logic [0:0]               s_tuser   = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [VEC_N*FIELD_W-1:0] m_tdata;
    logic [0:0]               m_tuser;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data  = '0;

    int errors;
    int pending;
    int checked;
    int clipped;
    int idle_cycles = 0;
    int burst_left  = 0;
    int settings    = 1;
    bit steady      = 1'b0;
    bit squeeze_req  = 1'b0;
    bit squeeze_done = 1'b0;

    logic [FIELD_W-1:0] mtx [VEC_N][VEC_N];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    vertex_transform_4x4 #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    vt44_checker #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_clipped   (clipped)
    );

    function automatic logic [FIELD_W-1:0] rand_q(input t_mix mix);
        t_mix pick;
        pick = (mix == MIX_ANY) ? t_mix'($urandom_range(0, 2)) : mix;
        case (pick)
            MIX_FULL: begin
                return $urandom;
            end
            MIX_SMALL: begin
                return $urandom_range(0, 1 << 18) - (1 << 17);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return Q_NEG;
                    default: return Q_ONE;
                endcase
            end
        endcase
    endfunction

    task automatic push_vertex(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                               input logic [FIELD_W-1:0] z, input logic [FIELD_W-1:0] w,
                               input logic dir);
        int gap;
        s_tdata  <= {w, z, y, x};
        s_tuser  <= dir;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = steady ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_matrix(input int junk);
        t_reg_idx ri;
        int       row;
        int       col;
        ri = ri.first();
        for (int n = 0; n < NUM_REGS; n++) begin
            row = int'(ri) / 2;
            col = (int'(ri) % 2) * 2;
            write_reg(ri, {mtx[row][col+1], mtx[row][col]});
            ri = ri.next();
        end
        for (int n = 0; n < junk; n++) begin
            write_reg(NUM_REGS + $urandom_range(0, (1 << CFG_IDX_W) - NUM_REGS - 1),
                      {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic fill_matrix(input logic [FIELD_W-1:0] value);
        for (int r = 0; r < VEC_N; r++) begin
            for (int c = 0; c < VEC_N; c++) begin
                mtx[r][c] = value;
            end
        end
    endtask

    initial begin
        t_sink mode;
        int    span;
        wait (rst_n);
        forever begin
            if (squeeze_req && !squeeze_done) begin
                squeeze_done = 1'b1;
                for (int n = 0; n < SQUEEZE_CYCLES; n++) begin
                    @(posedge clk);
                    m_tready <= 1'b0;
                end
            end
            mode = t_sink'($urandom_range(0, 3));
            span = $urandom_range(10, 150);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    SINK_OPEN: m_tready <= 1'b1;
                    SINK_HALF: m_tready <= ($urandom_range(0, 1) == 1);
                    SINK_EASY: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_mix mat_mix;
        t_mix vec_mix;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity matrix straight out of reset.
        push_vertex('0, '0, '0, '0, 1'b0);
        push_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        push_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        push_vertex(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1);
        push_vertex(Q_NEG, Q_ONE, -Q_ONE, Q_HALF, 1'b0);
        drain();

        // Largest positive elements: clipping both ways and rounding down.
        fill_matrix(Q_MAX);
        load_matrix(0);
        push_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        push_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        push_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
        push_vertex(Q_NEG, '0, '0, '0, 1'b0);
        drain();

        // Most negative elements: the widest possible sums.
        fill_matrix(Q_MIN);
        load_matrix(0);
        push_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        push_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        push_vertex('0, '0, '0, '0, 1'b1);
        drain();

        // Row 3 clips only when w takes part; unused register indexes are ignored.
        fill_matrix(Q_HALF);
        for (int c = 0; c < VEC_N; c++) begin
            mtx[VEC_N-1][c] = Q_MAX;
        end
        load_matrix(4);
        push_vertex(Q_NEG, Q_NEG, Q_NEG, Q_MAX, 1'b1);
        push_vertex(Q_NEG, Q_NEG, Q_NEG, Q_MAX, 1'b0);
        push_vertex(32'd1, '0, '0, '0, 1'b0);
        push_vertex(Q_NEG, '0, '0, '0, 1'b0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mat_mix = t_mix'(p % 4);
            for (int r = 0; r < VEC_N; r++) begin
                for (int c = 0; c < VEC_N; c++) begin
                    mtx[r][c] = rand_q(mat_mix);
                end
            end
            load_matrix(2);
            steady = (p % 3 == 1);
            if (p == 1) begin
                squeeze_req = 1'b1;
            end
            for (int i = 0; i < PHASE_VECTORS; i++) begin
                vec_mix = t_mix'($urandom_range(0, 3));
                push_vertex(rand_q(vec_mix), rand_q(vec_mix), rand_q(vec_mix), rand_q(vec_mix),
                            $urandom_range(0, 3) == 0);
            end
            drain();
        end

        $display("Checked %0d transformed vectors under %0d matrix settings, %0d of them clipped.",
                 checked, settings, clipped);
        $display("Included extreme elements, direction mode, unused register writes and a %0d-cycle output hold.",
                 SQUEEZE_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/vt44_pkg.sv
design/vt44_matrix.sv
design/vt44_mul.sv
design/vt44_sum.sv
design/vt44_sat.sv
design/vertex_transform_4x4.sv
test/vt44_checker.sv
test/tb.sv
